/* rtl/core/lcrc_pkg.sv */
`timescale 1ns / 1ps

package lcrc_pkg;

    localparam int unsigned IDX_W    = 4;
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QIDX_W   = 2;
    localparam int unsigned QCNT_W   = 3;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic CFG_CRC_INIT = 1'b0;
    localparam logic CFG_CRC_SPAN = 1'b1;

    localparam logic [3:0] CRC_SPAN_RESET = 4'd6;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_check;
        logic       frame_end;
    } beat_t;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    // Eight shift-and-reduce steps of the MSB-first CRC for one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
        logic [15:0] c;
        c = crc ^ {v, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/lsb_first_crc16_tx_framer.sv */
`timescale 1ns / 1ps

// The beats of a byte enter the registered output queue behind any beats still waiting.
// Throughput: one payload byte per cycle while the queue has room; the last byte of a
// frame adds two CRC beats, and all beats leave through the single output port.
// Reset (aresetn low, synchronous) empties the four-entry output queue, restarts the
// frame and sets crc_init to 0 and crc_span to 6.
module lsb_first_crc16_tx_framer #(
    parameter int unsigned MAX_PAYLOAD = 10
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_is_check,
    output logic        m_frame_end
);

    localparam logic [lcrc_pkg::IDX_W-1:0] MAX_IDX = lcrc_pkg::IDX_W'(MAX_PAYLOAD);

    logic [15:0]                   crc_init_reg;
    logic [3:0]                    crc_span_reg;
    logic [15:0]                   crc_acc_reg, crc_acc_next;
    logic [lcrc_pkg::IDX_W-1:0]    byte_index_reg, byte_index_next;
    logic [lcrc_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    lcrc_pkg::beat_t               q_reg [lcrc_pkg::QDEPTH];
    lcrc_pkg::beat_t               q_next [lcrc_pkg::QDEPTH];

    logic                          pop, push, in_range;
    logic [15:0]                   crc_seed, crc_new;
    lcrc_pkg::beat_t               new_beats [3];
    logic [1:0]                    new_n;
    logic [lcrc_pkg::QCNT_W-1:0]   base;

    assign m_valid     = (cnt_reg != '0);
    assign pop         = m_valid && m_ready;
    assign base        = cnt_reg - lcrc_pkg::QCNT_W'(pop);
    // Room for the worst case of three beats once this cycle's transfer has left.
    assign s_ready     = (base <= lcrc_pkg::QCNT_W'(1));
    assign push        = s_valid && s_ready;

    assign m_out_byte  = q_reg[0].out_byte;
    assign m_is_check  = q_reg[0].is_check;
    assign m_frame_end = q_reg[0].frame_end;

    always_comb begin
        crc_seed = (byte_index_reg == '0) ? crc_init_reg : crc_acc_reg;
        in_range = (byte_index_reg < MAX_IDX);
        if (in_range && (byte_index_reg < crc_span_reg)) begin
            crc_new = lcrc_pkg::crc_byte(crc_seed, s_data_byte);
        end else begin
            crc_new = crc_seed;
        end

        if (in_range) begin
            new_beats[0] = '{lcrc_pkg::flip8(s_data_byte), 1'b0, 1'b0};
            new_beats[1] = '{lcrc_pkg::flip8(crc_new[15:8]), 1'b1, 1'b0};
            new_beats[2] = '{lcrc_pkg::flip8(crc_new[7:0]), 1'b1, 1'b1};
            new_n        = s_frame_last ? 2'd3 : 2'd1;
        end else begin
            new_beats[0] = '{lcrc_pkg::flip8(crc_new[15:8]), 1'b1, 1'b0};
            new_beats[1] = '{lcrc_pkg::flip8(crc_new[7:0]), 1'b1, 1'b1};
            new_beats[2] = '{8'h00, 1'b0, 1'b0};
            new_n        = s_frame_last ? 2'd2 : 2'd0;
        end

        if (s_frame_last) begin
            byte_index_next = '0;
            crc_acc_next    = crc_init_reg;
        end else begin
            byte_index_next = in_range ? byte_index_reg + lcrc_pkg::IDX_W'(1) : byte_index_reg;
            crc_acc_next    = crc_new;
        end
    end

    always_comb begin
        for (int i = 0; i < lcrc_pkg::QDEPTH; i++) begin
            if (pop && (i < lcrc_pkg::QDEPTH - 1)) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            for (int k = 0; k < 3; k++) begin
                if (push && (k < int'(new_n)) &&
                    (lcrc_pkg::QCNT_W'(i) == base + lcrc_pkg::QCNT_W'(k))) begin
                    q_next[i] = new_beats[k];
                end
            end
        end
        cnt_next = base + (push ? lcrc_pkg::QCNT_W'(new_n) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_init_reg   <= 16'h0000;
            crc_span_reg   <= lcrc_pkg::CRC_SPAN_RESET;
            crc_acc_reg    <= 16'h0000;
            byte_index_reg <= '0;
            cnt_reg        <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    lcrc_pkg::CFG_CRC_INIT: crc_init_reg <= cfg_wdata;
                    lcrc_pkg::CFG_CRC_SPAN: crc_span_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (push) begin
                crc_acc_reg    <= crc_acc_next;
                byte_index_reg <= byte_index_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < lcrc_pkg::QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= lcrc_pkg::QCNT_W'(lcrc_pkg::QDEPTH))
        else $error("output queue overfilled");

    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (cnt_reg <= lcrc_pkg::QCNT_W'(2)))
        else $error("input taken without room for three beats");

    a_last_beats: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_frame_last) |=> (cnt_reg >= lcrc_pkg::QCNT_W'(2)))
        else $error("CRC beats missing after last byte");

    a_end_is_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_is_check)
        else $error("frame end on a payload beat");

    a_index_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_frame_last) |=> (byte_index_reg == '0))
        else $error("frame not restarted after last byte");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned PAYLOAD_MAX    = 10;
    localparam int unsigned RAND_PHASES    = 8;
    localparam int unsigned PHASE_ITEMS    = 52;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } payload_t;

    typedef struct packed {
        logic [7:0] air_byte;
        logic       crc_beat;
        logic       eof_beat;
    } air_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = lcrc_pkg::CFG_CRC_INIT;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_frame_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_is_check;
    logic        m_frame_end;

    // Bytes waiting to be offered, and beats the framer still owes us.
    payload_t  payload_pending[$];
    air_beat_t air_expected[$];

    // Copy of the framer state and its registers.
    logic [15:0] crc_run = 16'h0000;
    logic [3:0]  pay_count = 4'd0;
    logic [15:0] crc_seed = 16'h0000;
    logic [3:0]  crc_cover = lcrc_pkg::CRC_SPAN_RESET;

    int unsigned bytes_pushed = 0;
    int unsigned bytes_taken = 0;
    int unsigned gen_pos = 0;
    int unsigned phase_count = 0;
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned beats_checked = 0;
    int unsigned frames_closed = 0;
    int unsigned bytes_dropped = 0;
    int unsigned settings_used = 1;
    bit          calm = 1'b0;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    payload_t    next_item;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [3:0]  stall_pos = 4'd0;

    lsb_first_crc16_tx_framer #(
        .MAX_PAYLOAD(PAYLOAD_MAX)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_frame_last(s_frame_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_is_check  (m_is_check),
        .m_frame_end (m_frame_end)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] bit_mirror(input logic [7:0] b);
        return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
    endfunction

    // The CRC is fed one message bit at a time, most significant bit first.
    function automatic logic [15:0] crc16_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ lcrc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic predict_air_beats(input logic [7:0] b, input logic eof);
        logic [15:0] crc;
        crc = (pay_count == 4'd0) ? crc_seed : crc_run;
        if (pay_count < PAYLOAD_MAX) begin
            if (pay_count < crc_cover) begin
                crc = crc16_feed(crc, b);
            end
            air_expected.push_back('{air_byte: bit_mirror(b), crc_beat: 1'b0, eof_beat: 1'b0});
            pay_count = pay_count + 4'd1;
        end else begin
            bytes_dropped++;
        end
        crc_run = crc;
        if (eof) begin
            air_expected.push_back('{air_byte: bit_mirror(crc[15:8]), crc_beat: 1'b1,
                                     eof_beat: 1'b0});
            air_expected.push_back('{air_byte: bit_mirror(crc[7:0]), crc_beat: 1'b1,
                                     eof_beat: 1'b1});
            crc_run = crc_seed;
            pay_count = 4'd0;
            frames_closed++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        payload_pending.push_back('{data: b, eof: eof});
        bytes_pushed++;
        // Overlong bytes that carry no end of frame produce nothing and are not counted.
        if (gen_pos < PAYLOAD_MAX || eof) begin
            phase_count++;
        end
        if (eof) begin
            gen_pos = 0;
        end else if (gen_pos < PAYLOAD_MAX) begin
            gen_pos++;
        end
    endtask

    task automatic queue_random_frame();
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(0, 19);
        if (kind >= 16 && kind < 18) begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (kind >= 18) begin
            // A fragment with no end marker runs on into the next frame.
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end else begin
            if (kind < 12) begin
                len = $urandom_range(1, PAYLOAD_MAX);
            end else if (kind < 14) begin
                len = PAYLOAD_MAX;
            end else begin
                len = $urandom_range(PAYLOAD_MAX + 1, PAYLOAD_MAX + 6);
            end
            for (int i = 0; i < len; i++) begin
                send_byte(8'($urandom_range(0, 255)), i == len - 1);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (bytes_taken != bytes_pushed || air_expected.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == lcrc_pkg::CFG_CRC_INIT) begin
            crc_seed = val;
        end else begin
            crc_cover = val[3:0];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (payload_pending.size() != 0) begin
                next_item = payload_pending.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= next_item.data;
                s_frame_last <= next_item.eof;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if (calm || $urandom_range(0, 3) == 0) begin
                        gap_left = 0;
                    end else if ($urandom_range(0, 1) == 1) begin
                        gap_left = $urandom_range(1, 3);
                    end else begin
                        gap_left = $urandom_range(4, 12);
                    end
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a 16-bit pattern that is redrawn every time it wraps; in calm phases it is all ones.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_pos <= 4'd0;
        end else begin
            m_ready <= stall_pat[stall_pos];
            stall_pos <= stall_pos + 4'd1;
            if (stall_pos == 4'd15) begin
                if (calm) begin
                    stall_pat <= 16'hFFFF;
                end else begin
                    case ($urandom_range(0, 3))
                        0: stall_pat <= 16'hFFFF;
                        1: stall_pat <= 16'($urandom);
                        2: stall_pat <= 16'($urandom | $urandom);
                        default: stall_pat <= 16'($urandom & $urandom);
                    endcase
                end
            end
        end
    end

    // Results are checked before the byte of the same edge is predicted, since the output queue is registered.
    always @(posedge aclk) begin
        air_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beats_checked++;
                if (air_expected.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat %02h check %b end %b", $time,
                             m_out_byte, m_is_check, m_frame_end);
                end else begin
                    want = air_expected.pop_front();
                    if (m_out_byte !== want.air_byte) begin
                        errors++;
                        $display("%0t: out_byte expected %02h, got %02h", $time,
                                 want.air_byte, m_out_byte);
                    end
                    if (m_is_check !== want.crc_beat) begin
                        errors++;
                        $display("%0t: is_check expected %b, got %b", $time,
                                 want.crc_beat, m_is_check);
                    end
                    if (m_frame_end !== want.eof_beat) begin
                        errors++;
                        $display("%0t: frame_end expected %b, got %b", $time,
                                 want.eof_beat, m_frame_end);
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_air_beats(s_data_byte, s_frame_last);
                bytes_taken++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [15:0] init_v;
        logic [3:0]  span_v;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: seed 0, six bytes covered.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hA5, 1'b1);
        // Overlong frame: the eleventh byte is dropped, the twelfth still closes the frame.
        for (int i = 0; i < 12; i++) begin
            send_byte(8'(8'h3B * i + 8'h11), i == 11);
        end
        // A new seed written mid-frame must only apply from the next frame.
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        wait_drained();
        cfg_write(lcrc_pkg::CFG_CRC_INIT, 16'hFFFF);
        settings_used++;
        send_byte(8'h5A, 1'b1);
        send_byte(8'h12, 1'b1);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin init_v = 16'h0000; span_v = 4'd0; end
                1: begin init_v = 16'hFFFF; span_v = 4'd15; end
                2: begin init_v = 16'h1D0F; span_v = 4'd10; end
                3: begin init_v = 16'hFFFF; span_v = 4'd0; end
                4: begin init_v = 16'h0000; span_v = 4'd1; end
                5: begin init_v = 16'($urandom); span_v = 4'd11; end
                default: begin
                    init_v = 16'($urandom);
                    span_v = 4'($urandom_range(0, 15));
                end
            endcase
            wait_drained();
            cfg_write(lcrc_pkg::CFG_CRC_INIT, init_v);
            // Only the low four bits of the data word belong to the span register.
            cfg_write(lcrc_pkg::CFG_CRC_SPAN, {12'($urandom), span_v});
            settings_used++;
            calm = (ph == 2 || ph == 5);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                queue_random_frame();
            end
        end

        wait_drained();
        if (air_expected.size() != 0) begin
            errors += air_expected.size();
            $display("%0t: %0d beats never arrived", $time, air_expected.size());
        end
        $display("Sent %0d bytes in %0d closed frames, %0d dropped as overlong.",
                 bytes_taken, frames_closed, bytes_dropped);
        $display("Checked %0d output beats over %0d register settings, %0d errors.",
                 beats_checked, settings_used, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
